### rtl/kwc_pkg.sv
// Shared types, constants and helper functions for the keyword substitution cipher.
// Depends on nothing; every other file of the block but kwc_checker imports it.
`default_nettype none

package kwc_pkg;

	localparam int LETTER_COUNT = 26;
	localparam int KEY_BYTES_FIXED = 16;
	localparam logic [7:0] UPPER_A = 8'd65;
	localparam logic [7:0] LOWER_A = 8'd97;
	localparam logic [7:0] UPPER_END = 8'd91;
	localparam logic [7:0] LOWER_END = 8'd123;

	typedef logic [4:0] letter_t;
	typedef letter_t [LETTER_COUNT-1:0] table_t;

	typedef enum logic [1:0] {
		REG_KEY_LOW  = 2'd0,
		REG_KEY_HIGH = 2'd1,
		REG_KEY_LEN  = 2'd2,
		REG_DECODE   = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		BLD_KEY,
		BLD_FILL,
		BLD_DONE
	} bld_state_t;

	typedef struct packed {
		logic is_letter;
		letter_t idx;
	} letter_info_t;

	typedef struct packed {
		logic restart;
		logic [8*KEY_BYTES_FIXED-1:0] bytes;
		logic [4:0] length;
	} kw_cfg_t;

	function automatic letter_info_t letter_index(input logic [7:0] b);
		letter_info_t r;
		logic [7:0] d;
		r.is_letter = 1'b0;
		r.idx = '0;
		d = '0;
		if (b >= UPPER_A && b < UPPER_END) begin
			d = b - UPPER_A;
			r.is_letter = 1'b1;
			r.idx = d[4:0];
		end else if (b >= LOWER_A && b < LOWER_END) begin
			d = b - LOWER_A;
			r.is_letter = 1'b1;
			r.idx = d[4:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/kwc_builder.sv
// Table builder: walks the keyword, then the alphabet, one step a cycle, and fills
// the substitution and inverse tables. Depends on kwc_pkg.
`default_nettype none

module kwc_builder
	import kwc_pkg::*;
#(
	parameter int KEYWORD_MAX_BYTES = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire kw_cfg_t kw,
	output logic         ready,
	output table_t       sub_table,
	output table_t       inv_table
);

	bld_state_t state_q, state_nxt;
	logic [4:0] pos_q;
	letter_t fill_q;
	logic [LETTER_COUNT-1:0] used_q;
	table_t sub_q, inv_q;

	logic [4:0] len_sat;
	letter_info_t key_info;
	logic key_active, fill_active, place;
	letter_t wr_letter;

	assign len_sat = (kw.length > 5'(KEYWORD_MAX_BYTES)) ? 5'(KEYWORD_MAX_BYTES) : kw.length;
	assign key_info = letter_index(kw.bytes[{pos_q[3:0], 3'b000} +: 8]);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BLD_KEY: begin
				if (pos_q >= len_sat)
					state_nxt = BLD_FILL;
			end
			BLD_FILL: begin
				if (pos_q == 5'(LETTER_COUNT - 1))
					state_nxt = BLD_DONE;
			end
			BLD_DONE: state_nxt = BLD_DONE;
			default: state_nxt = BLD_KEY;
		endcase
		if (kw.restart)
			state_nxt = BLD_KEY;
	end

	always_comb begin
		key_active = 1'b0;
		fill_active = 1'b0;
		wr_letter = '0;
		ready = 1'b0;
		case (state_q)
			BLD_KEY: begin
				key_active = (pos_q < len_sat);
				wr_letter = key_info.idx;
			end
			BLD_FILL: begin
				fill_active = 1'b1;
				wr_letter = pos_q;
			end
			BLD_DONE: ready = 1'b1;
			default: ready = 1'b0;
		endcase
		place = ((key_active && key_info.is_letter) || fill_active) && !used_q[wr_letter];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BLD_KEY;
			pos_q <= '0;
			fill_q <= '0;
			used_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (kw.restart) begin
				pos_q <= '0;
				fill_q <= '0;
				used_q <= '0;
			end else begin
				if (state_q == BLD_KEY)
					pos_q <= key_active ? pos_q + 5'd1 : '0;
				else if (state_q == BLD_FILL)
					pos_q <= pos_q + 5'd1;
				if (place && !kw.restart) begin
					used_q[wr_letter] <= 1'b1;
					fill_q <= fill_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (place && !kw.restart) begin
			sub_q[fill_q] <= wr_letter;
			inv_q[wr_letter] <= fill_q;
		end
	end

	assign sub_table = sub_q;
	assign inv_table = inv_q;

endmodule

`default_nettype wire

### rtl/kwc_datapath.sv
// Three-stage byte pipeline: letter detection, table lookup, output formation.
// Depends on kwc_pkg; the tables come from kwc_builder.
`default_nettype none

module kwc_datapath
	import kwc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] byte_in,
	input  wire logic       decode,
	input  wire table_t     sub_table,
	input  wire table_t     inv_table,
	input  wire logic       dst_stall,
	output logic            en_s1,
	output logic            dst_valid,
	output logic [7:0]      symbol_out
);

	logic v_s1, v_s2, v_s3;
	logic [7:0] byte_s1, byte_s2, sym_s3;
	letter_info_t info_s1;
	logic letter_s2;
	letter_t code_s2;
	logic en_s2, en_s3;
	letter_info_t info_in;
	letter_t code_nxt;
	logic [7:0] sym_nxt;

	assign en_s3 = !v_s3 || !dst_stall;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign info_in = letter_index(byte_in);
	assign code_nxt = decode ? inv_table[info_s1.idx] : sub_table[info_s1.idx];
	assign sym_nxt = letter_s2 ? (UPPER_A + {3'b000, code_s2}) : byte_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1)
				v_s1 <= take;
			if (en_s2)
				v_s2 <= v_s1;
			if (en_s3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && take) begin
			byte_s1 <= byte_in;
			info_s1 <= info_in;
		end
		if (en_s2 && v_s1) begin
			byte_s2 <= byte_s1;
			letter_s2 <= info_s1.is_letter;
			code_s2 <= code_nxt;
		end
		if (en_s3 && v_s2)
			sym_s3 <= sym_nxt;
	end

	assign dst_valid = v_s3;
	assign symbol_out = sym_s3;

endmodule

`default_nettype wire

### rtl/keyword_substitution_cipher.sv
// Top level of the keyword substitution cipher: configuration registers, table
// builder and byte pipeline. Depends on kwc_pkg, kwc_builder and kwc_datapath.
//
//   Channel  Handshake             Payload
//   source   src_valid/src_stall   symbol_in[7:0]
//   sink     dst_valid/dst_stall   symbol_out[7:0]
//   config   cfg_we                cfg_index[1:0], cfg_data[63:0]
//
// One byte per cycle is accepted while src_stall is low; an accepted byte passes the s1,
// s2 and s3 registers, and dst_valid rises once it reaches s3.
// After reset and after every configuration write the builder walks the keyword and
// then the alphabet; src_stall is high meanwhile. A stall on the sink freezes, in the
// same cycle, every full stage from the last back to the first empty one; src_stall
// follows combinationally once all three stages hold data, and an empty stage lets
// the stages before it advance into it.
`default_nettype none

module keyword_substitution_cipher
	import kwc_pkg::*;
#(
	parameter int KEYWORD_MAX_BYTES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        src_valid,
	output logic             src_stall,
	input  wire logic [7:0]  symbol_in,
	output logic             dst_valid,
	input  wire logic        dst_stall,
	output logic [7:0]       symbol_out,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	logic [63:0] key_low_q, key_high_q;
	logic [4:0] key_len_q;
	logic decode_q;
	kw_cfg_t kw;
	logic ready, en_s1;
	table_t sub_table, inv_table;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= '0;
			key_len_q <= '0;
			decode_q <= 1'b0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_KEY_LOW:  key_low_q <= cfg_data;
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LEN:  key_len_q <= cfg_data[4:0];
				REG_DECODE:   decode_q <= cfg_data[0];
				default:      decode_q <= decode_q;
			endcase
		end
	end

	assign kw.restart = cfg_we;
	assign kw.bytes = {key_high_q, key_low_q};
	assign kw.length = key_len_q;

	kwc_builder #(
		.KEYWORD_MAX_BYTES(KEYWORD_MAX_BYTES)
	) u_builder (
		.clk      (clk),
		.arst_n   (arst_n),
		.kw       (kw),
		.ready    (ready),
		.sub_table(sub_table),
		.inv_table(inv_table)
	);

	assign src_stall = !ready || !en_s1;

	kwc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (src_valid && !src_stall),
		.byte_in   (symbol_in),
		.decode    (decode_q),
		.sub_table (sub_table),
		.inv_table (inv_table),
		.dst_stall (dst_stall),
		.en_s1     (en_s1),
		.dst_valid (dst_valid),
		.symbol_out(symbol_out)
	);

endmodule

`default_nettype wire

### rtl/kwc_checker.sv
// Port-level checks for the keyword substitution cipher, bound to its top level.
// Depends on nothing but the top level's ports.
`default_nettype none

module kwc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        src_valid,
	input wire logic        src_stall,
	input wire logic        dst_valid,
	input wire logic        dst_stall,
	input wire logic [7:0]  symbol_out,
	input wire logic        cfg_we
);

	a_cfg_blocks_source: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> src_stall)
		else $error("source accepted a transaction while the tables were rebuilt");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && !src_stall ##1 !dst_stall ##1 !dst_stall) |=> dst_valid)
		else $error("accepted transaction did not reach the sink in three cycles");

	a_sink_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && dst_stall) |=> (dst_valid && $stable(symbol_out)))
		else $error("stalled result transaction changed or vanished");

endmodule

bind keyword_substitution_cipher kwc_checker u_kwc_checker (.*);

`default_nettype wire
